// File: hdl/gcls_pkg.sv
// Shared constants, types and command patterns for the G-code line axis stepper.
package gcls_pkg;

    localparam int LINE_CAPACITY = 32;
    localparam int CNT_W = $clog2(LINE_CAPACITY);

    localparam logic [15:0] STEP_PERIOD_RST   = 16'd100;
    localparam logic [15:0] REPORT_PERIOD_RST = 16'd2000;
    localparam logic [31:0] POS_RST           = 32'sd50;

    localparam logic [7:0] CH_NEWLINE = 8'd10;

    // prefix flag bits
    localparam int FLG_STOP = 0;
    localparam int FLG_GOTO = 1;
    localparam int FLG_HOME = 2;

    localparam logic [7:0] PAT_STOP [0:1] = '{8'h4D, 8'h30};               // "M0"
    localparam logic [7:0] PAT_GOTO [0:3] = '{8'h47, 8'h30, 8'h20, 8'h58}; // "G0 X"
    localparam logic [7:0] PAT_HOME [0:2] = '{8'h47, 8'h32, 8'h38};        // "G28"

    typedef enum logic [0:0] {
        CFG_STEP_PERIOD   = 1'b0,
        CFG_REPORT_PERIOD = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        KIND_STOP_OK  = 3'd0,
        KIND_GOTO_ACK = 3'd1,
        KIND_HOME_ACK = 3'd2,
        KIND_REPORT   = 3'd3,
        KIND_MOVE_OK  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        NUM_SKIP   = 2'd0,
        NUM_SIGN   = 2'd1,
        NUM_DIGITS = 2'd2,
        NUM_DONE   = 2'd3
    } num_phase_t;

    // results caused by one input word
    typedef struct packed {
        logic [1:0]  cnt;
        kind_t       kind0;
        logic [31:0] value0;
        kind_t       kind1;
        logic [31:0] value1;
    } res_pair_t;

endpackage

// File: hdl/gcls_core.sv
// Command line parser, tick counters and axis position state.
module gcls_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [0:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_fire,
    input  logic                in_mode,
    input  logic [7:0]          in_byte,
    output gcls_pkg::res_pair_t res
);
    import gcls_pkg::*;

    logic [15:0]      step_period_reg, report_period_reg;
    logic [31:0]      position_reg, position_next;
    logic [31:0]      target_reg, target_next;
    logic             moving_reg, moving_next;
    logic [CNT_W-1:0] char_count_reg, char_count_next;
    logic [2:0]       flags_reg, flags_next;
    num_phase_t       phase_reg, phase_next;
    logic [31:0]      accum_reg, accum_next;
    logic             neg_reg, neg_next;
    logic [15:0]      step_ticks_reg, step_ticks_next;
    logic [15:0]      report_ticks_reg, report_ticks_next;

    logic [16:0] step_inc, report_inc, step_p, report_p;
    logic [35:0] prod;
    logic [31:0] num_value, pos_moved;
    logic        is_digit, is_space, stored;
    logic [CNT_W-1:0] cnt_upd;
    logic [2:0]  flags_upd;
    num_phase_t  phase_upd;
    logic [31:0] accum_upd;
    logic        neg_upd;

    always_comb begin
        step_p   = (step_period_reg == 16'd0) ? 17'd1 : {1'b0, step_period_reg};
        report_p = (report_period_reg == 16'd0) ? 17'd1 : {1'b0, report_period_reg};
        step_inc   = {1'b0, step_ticks_reg} + 17'd1;
        report_inc = {1'b0, report_ticks_reg} + 17'd1;
        pos_moved  = ($signed(position_reg) > $signed(target_reg)) ?
                     position_reg - 32'd1 : position_reg + 32'd1;

        is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
        is_space = (in_byte == 8'd32) || ((in_byte >= 8'd9) && (in_byte <= 8'd13));
        prod = ({4'd0, accum_reg} << 3) + ({4'd0, accum_reg} << 1)
             + {32'd0, in_byte[3:0] - 4'd0};

        // line storage, prefix matching and number parsing
        stored    = ({1'b0, char_count_reg} < (CNT_W+1)'(LINE_CAPACITY - 1));
        cnt_upd   = char_count_reg;
        flags_upd = flags_reg;
        phase_upd = phase_reg;
        accum_upd = accum_reg;
        neg_upd   = neg_reg;
        if (stored) begin
            cnt_upd = char_count_reg + CNT_W'(1);
            if (char_count_reg < CNT_W'(2) && in_byte != PAT_STOP[char_count_reg[0]])
                flags_upd[FLG_STOP] = 1'b0;
            if (char_count_reg < CNT_W'(4) && in_byte != PAT_GOTO[char_count_reg[1:0]])
                flags_upd[FLG_GOTO] = 1'b0;
            if (char_count_reg < CNT_W'(3) && in_byte != PAT_HOME[char_count_reg[1:0]])
                flags_upd[FLG_HOME] = 1'b0;
            if (char_count_reg >= CNT_W'(4)) begin
                if (phase_reg == NUM_SKIP && is_space) begin
                    phase_upd = NUM_SKIP;
                end else if (phase_reg == NUM_SKIP && (in_byte == 8'h2B || in_byte == 8'h2D)) begin
                    neg_upd   = (in_byte == 8'h2D);
                    phase_upd = NUM_SIGN;
                end else if (phase_reg != NUM_DONE && is_digit) begin
                    accum_upd = (prod > 36'h080000000) ? 32'h80000000 : prod[31:0];
                    phase_upd = NUM_DIGITS;
                end else begin
                    phase_upd = NUM_DONE;
                end
            end
        end

        if (neg_upd)
            num_value = accum_upd[31] ? 32'h80000000 : (32'd0 - accum_upd);
        else
            num_value = accum_upd[31] ? 32'h7FFFFFFF : accum_upd;

        position_next     = position_reg;
        target_next       = target_reg;
        moving_next       = moving_reg;
        char_count_next   = char_count_reg;
        flags_next        = flags_reg;
        phase_next        = phase_reg;
        accum_next        = accum_reg;
        neg_next          = neg_reg;
        step_ticks_next   = step_ticks_reg;
        report_ticks_next = report_ticks_reg;
        res = '{cnt: 2'd0, kind0: KIND_STOP_OK, value0: position_reg,
                kind1: KIND_STOP_OK, value1: position_reg};

        if (in_mode) begin
            if (report_ticks_reg == 16'd0) begin
                res.cnt    = 2'd1;
                res.kind0  = KIND_REPORT;
                res.value0 = position_reg;
            end
            if (step_ticks_reg == 16'd0 && moving_reg && position_reg != target_reg) begin
                position_next = pos_moved;
                if (pos_moved == target_reg) begin
                    moving_next = 1'b0;
                    if (res.cnt == 2'd0) begin
                        res.kind0  = KIND_MOVE_OK;
                        res.value0 = pos_moved;
                    end else begin
                        res.kind1  = KIND_MOVE_OK;
                        res.value1 = pos_moved;
                    end
                    res.cnt = res.cnt + 2'd1;
                end
            end
            report_ticks_next = (report_inc >= report_p) ? 16'd0 : report_inc[15:0];
            step_ticks_next   = (step_inc >= step_p) ? 16'd0 : step_inc[15:0];
        end else if (in_byte != 8'd0) begin
            char_count_next = cnt_upd;
            flags_next      = flags_upd;
            phase_next      = phase_upd;
            accum_next      = accum_upd;
            neg_next        = neg_upd;
            if (in_byte == CH_NEWLINE) begin
                if (flags_upd[FLG_STOP] && cnt_upd >= CNT_W'(2)) begin
                    moving_next = 1'b0;
                    target_next = position_reg;
                    res.cnt     = 2'd1;
                    res.kind0   = KIND_STOP_OK;
                    res.value0  = position_reg;
                end else if (flags_upd[FLG_GOTO] && cnt_upd >= CNT_W'(4)) begin
                    moving_next = 1'b1;
                    target_next = num_value;
                    res.cnt     = 2'd1;
                    res.kind0   = KIND_GOTO_ACK;
                    res.value0  = num_value;
                end else if (flags_upd[FLG_HOME] && cnt_upd >= CNT_W'(3)) begin
                    moving_next = 1'b1;
                    res.cnt     = 2'd1;
                    res.kind0   = KIND_HOME_ACK;
                    res.value0  = position_reg;
                end
                char_count_next = '0;
                flags_next      = 3'b111;
                phase_next      = NUM_SKIP;
                accum_next      = '0;
                neg_next        = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_period_reg   <= STEP_PERIOD_RST;
            report_period_reg <= REPORT_PERIOD_RST;
            position_reg      <= POS_RST;
            target_reg        <= POS_RST;
            moving_reg        <= 1'b0;
            char_count_reg    <= '0;
            flags_reg         <= 3'b111;
            phase_reg         <= NUM_SKIP;
            accum_reg         <= '0;
            neg_reg           <= 1'b0;
            step_ticks_reg    <= '0;
            report_ticks_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_STEP_PERIOD:   step_period_reg   <= cfg_data;
                    CFG_REPORT_PERIOD: report_period_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_fire) begin
                position_reg     <= position_next;
                target_reg       <= target_next;
                moving_reg       <= moving_next;
                char_count_reg   <= char_count_next;
                flags_reg        <= flags_next;
                phase_reg        <= phase_next;
                accum_reg        <= accum_next;
                neg_reg          <= neg_next;
                step_ticks_reg   <= step_ticks_next;
                report_ticks_reg <= report_ticks_next;
            end
        end
    end

endmodule

// File: hdl/gcls_outq.sv
// Two-entry result register feeding the output stream.
module gcls_outq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  gcls_pkg::res_pair_t res,
    output logic                space,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,
    output logic [2:0]          m_tuser,
    output logic                m_tlast
);
    import gcls_pkg::*;

    logic [1:0]  cnt_reg;
    kind_t       head_kind_reg, tail_kind_reg;
    logic [31:0] head_val_reg, tail_val_reg;
    logic        head_last_reg;
    logic        pop;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    // room when the register is empty, or drains its final word this cycle
    assign space    = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign m_tdata  = head_val_reg;
    assign m_tuser  = head_kind_reg;
    assign m_tlast  = head_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (push) begin
            cnt_reg <= res.cnt;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            head_kind_reg <= res.kind0;
            head_val_reg  <= res.value0;
            head_last_reg <= (res.cnt == 2'd1);
            tail_kind_reg <= res.kind1;
            tail_val_reg  <= res.value1;
        end else if (pop) begin
            head_kind_reg <= tail_kind_reg;
            head_val_reg  <= tail_val_reg;
            head_last_reg <= 1'b1;
        end
    end

endmodule

// File: hdl/gcode_line_axis_stepper.sv
// Top level of the G-code line axis stepper.
// Input stream: s_tuser = 0 carries a received serial byte in s_tdata,
// s_tuser = 1 is a one millisecond tick. Nonzero bytes build a command line
// ended by newline; "M0", "G0 X<n>" and "G28" are recognized by prefix.
// Ticks drive the periodic position report and single steps of a move.
// Output stream: m_tuser is the result kind, m_tdata the 32-bit value,
// m_tlast marks the final word caused by one input word (at most two).
// Configuration: cfg_wr_en/cfg_index/cfg_data set step_period (0) and
// report_period (1); write only while the block is idle.
// Results are registered and appear in the cycle after the input word is accepted.
// Throughput: one input word per cycle while m_tready is high and each
// causes at most one result; after a word causing two results, the next
// word enters only as the two-entry result register drains its final word.
// Stall: while the receiver holds m_tready low with words pending,
// s_tready drops; no state is lost.
// Reset (aresetn low, synchronous): position and target 50, idle, empty
// line, counters zero, periods 100 and 2000, no results pending.
module gcode_line_axis_stepper (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast
);
    import gcls_pkg::*;

    res_pair_t res;
    logic      space;
    logic      in_fire;

    assign s_tready = space;
    assign in_fire  = s_tvalid && space;

    gcls_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .in_mode   (s_tuser),
        .in_byte   (s_tdata),
        .res       (res)
    );

    gcls_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (in_fire),
        .res      (res),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
